FILE: sv/ncle_pkg.sv
// ----------------------------------------------------------------------------
// ncle_pkg
// Shared types, request codes and lookup tables for the noise voice core.
// ----------------------------------------------------------------------------
package ncle_pkg;

   localparam int NCLE_TIMER_WIDTH = 12;
   localparam int NCLE_QUEUE_DEPTH = 4;

   localparam logic [2:0] REQ_REG_WRITE = 3'd0;
   localparam logic [2:0] REQ_TIMER     = 3'd1;
   localparam logic [2:0] REQ_ENVELOPE  = 3'd2;
   localparam logic [2:0] REQ_LENGTH    = 3'd3;
   localparam logic [2:0] REQ_ENABLE    = 3'd4;

   localparam logic [1:0] REG_CONTROL = 2'd0;
   localparam logic [1:0] REG_PERIOD  = 2'd2;
   localparam logic [1:0] REG_LENGTH  = 2'd3;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CONTROL,
      OP_PERIOD,
      OP_LOAD_LENGTH,
      OP_TIMER,
      OP_ENVELOPE,
      OP_LENGTH,
      OP_ENABLE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

   function automatic logic [15:0] period_lookup(input logic [3:0] idx);
      logic [15:0] val;
      case (idx)
         4'd0:    val = 16'd4;
         4'd1:    val = 16'd8;
         4'd2:    val = 16'd16;
         4'd3:    val = 16'd32;
         4'd4:    val = 16'd64;
         4'd5:    val = 16'd96;
         4'd6:    val = 16'd128;
         4'd7:    val = 16'd160;
         4'd8:    val = 16'd202;
         4'd9:    val = 16'd254;
         4'd10:   val = 16'd380;
         4'd11:   val = 16'd508;
         4'd12:   val = 16'd762;
         4'd13:   val = 16'd1016;
         4'd14:   val = 16'd2034;
         default: val = 16'd4068;
      endcase
      return val;
   endfunction

   function automatic logic [7:0] length_lookup(input logic [4:0] idx);
      logic [7:0] val;
      case (idx)
         5'd0:    val = 8'd10;
         5'd1:    val = 8'd254;
         5'd2:    val = 8'd20;
         5'd3:    val = 8'd2;
         5'd4:    val = 8'd40;
         5'd5:    val = 8'd4;
         5'd6:    val = 8'd80;
         5'd7:    val = 8'd6;
         5'd8:    val = 8'd160;
         5'd9:    val = 8'd8;
         5'd10:   val = 8'd60;
         5'd11:   val = 8'd10;
         5'd12:   val = 8'd14;
         5'd13:   val = 8'd12;
         5'd14:   val = 8'd26;
         5'd15:   val = 8'd14;
         5'd16:   val = 8'd12;
         5'd17:   val = 8'd16;
         5'd18:   val = 8'd24;
         5'd19:   val = 8'd18;
         5'd20:   val = 8'd48;
         5'd21:   val = 8'd20;
         5'd22:   val = 8'd96;
         5'd23:   val = 8'd22;
         5'd24:   val = 8'd192;
         5'd25:   val = 8'd24;
         5'd26:   val = 8'd72;
         5'd27:   val = 8'd26;
         5'd28:   val = 8'd16;
         5'd29:   val = 8'd28;
         5'd30:   val = 8'd32;
         default: val = 8'd30;
      endcase
      return val;
   endfunction

endpackage

FILE: sv/noise_channel_lfsr_envelope_core.sv
// ----------------------------------------------------------------------------
// noise_channel_lfsr_envelope_core
// Noise voice with a 15-bit shift register, period timer, length counter
// and decay envelope; one result beat for every request beat.
//
//   Channel  Direction  Payload
//   req_     in         tuser: request type; tdata: register index, data byte
//   rsp_     out        tdata: sample level, length-active flag
//
// One request beat is accepted per clock unless the front register is held
// by a full queue; each result passes through the front register, the queue
// and the result register. Throughput is set by the back-end state update.
// A synchronous reset clears all voice state and the command queue.
// A stalled result port fills the four-entry queue before requests stall.
// ----------------------------------------------------------------------------
module noise_channel_lfsr_envelope_core #(
   parameter int TIMER_WIDTH = ncle_pkg::NCLE_TIMER_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,  // [2:0] req_type
   input  logic [15:0] req_tdata,  // [1:0] reg_offset, [9:2] write_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // [3:0] sample, [4] length_active
);

   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_empty;
   ncle_pkg::cmd_type push_cmd;
   ncle_pkg::cmd_type pop_cmd;

   ncle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   ncle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (queue_empty)
   );

   ncle_back #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .pop_cmd     (pop_cmd),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

FILE: sv/ncle_front.sv
// ----------------------------------------------------------------------------
// ncle_front
// Accepts requests and decodes them into internal commands.
// ----------------------------------------------------------------------------
module ncle_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [2:0]        req_tuser,  // [2:0] req_type
   input  logic [15:0]       req_tdata,  // [1:0] reg_offset, [9:2] write_data
   output logic              push,
   output ncle_pkg::cmd_type push_cmd,
   input  logic              queue_full
);

   logic              valid_ff;
   logic              valid_in;
   ncle_pkg::cmd_type cmd_ff;
   ncle_pkg::cmd_type cmd_in;
   ncle_pkg::op_type  op_dec;

   always_comb begin
      op_dec = ncle_pkg::OP_NONE;
      unique case (req_tuser)
         ncle_pkg::REQ_REG_WRITE: begin
            unique case (req_tdata[1:0])
               ncle_pkg::REG_CONTROL: op_dec = ncle_pkg::OP_CONTROL;
               ncle_pkg::REG_PERIOD:  op_dec = ncle_pkg::OP_PERIOD;
               ncle_pkg::REG_LENGTH:  op_dec = ncle_pkg::OP_LOAD_LENGTH;
               default:               op_dec = ncle_pkg::OP_NONE;
            endcase
         end
         ncle_pkg::REQ_TIMER:    op_dec = ncle_pkg::OP_TIMER;
         ncle_pkg::REQ_ENVELOPE: op_dec = ncle_pkg::OP_ENVELOPE;
         ncle_pkg::REQ_LENGTH:   op_dec = ncle_pkg::OP_LENGTH;
         ncle_pkg::REQ_ENABLE:   op_dec = ncle_pkg::OP_ENABLE;
         default:                op_dec = ncle_pkg::OP_NONE;
      endcase
   end

   assign push       = valid_ff && !queue_full;
   assign req_tready = !valid_ff || !queue_full;
   assign push_cmd   = cmd_ff;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         valid_in    = 1'b1;
         cmd_in.op   = op_dec;
         cmd_in.data = req_tdata[9:2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

FILE: sv/ncle_queue.sv
// ----------------------------------------------------------------------------
// ncle_queue
// Small command queue between the decode front and the execution back end.
// ----------------------------------------------------------------------------
module ncle_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ncle_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output ncle_pkg::cmd_type pop_cmd,
   output logic              empty
);

   localparam int PtrW = $clog2(ncle_pkg::NCLE_QUEUE_DEPTH);
   localparam int CntW = $clog2(ncle_pkg::NCLE_QUEUE_DEPTH + 1);

   ncle_pkg::cmd_type        mem_ff [ncle_pkg::NCLE_QUEUE_DEPTH];
   logic [PtrW-1:0]          wr_ptr_ff;
   logic [PtrW-1:0]          wr_ptr_in;
   logic [PtrW-1:0]          rd_ptr_ff;
   logic [PtrW-1:0]          rd_ptr_in;
   logic [CntW-1:0]          count_ff;
   logic [CntW-1:0]          count_in;

   assign full    = (count_ff == CntW'(ncle_pkg::NCLE_QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("Command queue written while full.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("Command queue read while empty.");
`endif

endmodule

FILE: sv/ncle_back.sv
// ----------------------------------------------------------------------------
// ncle_back
// Executes commands on the voice state and holds the result register.
// ----------------------------------------------------------------------------
module ncle_back #(
   parameter int TIMER_WIDTH = ncle_pkg::NCLE_TIMER_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  ncle_pkg::cmd_type pop_cmd,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata  // [3:0] sample, [4] length_active
);

   logic [14:0]            lfsr_ff;
   logic [14:0]            lfsr_in;
   logic [TIMER_WIDTH-1:0] timer_ff;
   logic [TIMER_WIDTH-1:0] timer_in;
   logic [TIMER_WIDTH-1:0] reload_ff;
   logic [TIMER_WIDTH-1:0] reload_in;
   logic                   short_ff;
   logic                   short_in;
   logic                   halt_ff;
   logic                   halt_in;
   logic                   const_vol_ff;
   logic                   const_vol_in;
   logic [3:0]             env_period_ff;
   logic [3:0]             env_period_in;
   logic [7:0]             length_ff;
   logic [7:0]             length_in;
   logic                   restart_ff;
   logic                   restart_in;
   logic [3:0]             divider_ff;
   logic [3:0]             divider_in;
   logic [3:0]             decay_ff;
   logic [3:0]             decay_in;
   logic                   enabled_ff;
   logic                   enabled_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [4:0]             rsp_data_ff;
   logic [4:0]             rsp_data_in;
   logic [15:0]            period_full;
   logic                   feedback;
   logic [3:0]             level;

   assign pop         = !queue_empty && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = {3'b000, rsp_data_ff};
   assign period_full = ncle_pkg::period_lookup(pop_cmd.data[3:0]);
   assign feedback    = lfsr_ff[0] ^ (short_ff ? lfsr_ff[6] : lfsr_ff[1]);

   always_comb begin
      lfsr_in       = lfsr_ff;
      timer_in      = timer_ff;
      reload_in     = reload_ff;
      short_in      = short_ff;
      halt_in       = halt_ff;
      const_vol_in  = const_vol_ff;
      env_period_in = env_period_ff;
      length_in     = length_ff;
      restart_in    = restart_ff;
      divider_in    = divider_ff;
      decay_in      = decay_ff;
      enabled_in    = enabled_ff;
      if (pop) begin
         case (pop_cmd.op)
            ncle_pkg::OP_CONTROL: begin
               halt_in       = pop_cmd.data[5];
               const_vol_in  = pop_cmd.data[4];
               env_period_in = pop_cmd.data[3:0];
            end
            ncle_pkg::OP_PERIOD: begin
               short_in  = pop_cmd.data[7];
               reload_in = period_full[TIMER_WIDTH-1:0];
            end
            ncle_pkg::OP_LOAD_LENGTH: begin
               if (enabled_ff) begin
                  length_in = ncle_pkg::length_lookup(pop_cmd.data[7:3]);
               end
               restart_in = 1'b1;
            end
            ncle_pkg::OP_TIMER: begin
               if (timer_ff == '0) begin
                  timer_in = reload_ff;
                  lfsr_in  = {feedback, lfsr_ff[14:1]};
               end else begin
                  timer_in = timer_ff - {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
               end
            end
            ncle_pkg::OP_ENVELOPE: begin
               if (restart_ff) begin
                  restart_in = 1'b0;
                  decay_in   = 4'd15;
                  divider_in = env_period_ff;
               end else if (divider_ff == 4'd0) begin
                  divider_in = env_period_ff;
                  if (decay_ff != 4'd0) begin
                     decay_in = decay_ff - 4'd1;
                  end else if (halt_ff) begin
                     decay_in = 4'd15;
                  end
               end else begin
                  divider_in = divider_ff - 4'd1;
               end
            end
            ncle_pkg::OP_LENGTH: begin
               if (!halt_ff && length_ff != 8'd0) begin
                  length_in = length_ff - 8'd1;
               end
            end
            ncle_pkg::OP_ENABLE: begin
               enabled_in = pop_cmd.data[0];
               if (!pop_cmd.data[0]) begin
                  length_in = 8'd0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (length_in == 8'd0 || lfsr_in[0]) begin
         level = 4'd0;
      end else begin
         level = const_vol_in ? env_period_in : decay_in;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(length_in != 8'd0), level};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff       <= 15'd1;
         timer_ff      <= '0;
         reload_ff     <= TIMER_WIDTH'(4);
         short_ff      <= 1'b0;
         halt_ff       <= 1'b0;
         const_vol_ff  <= 1'b0;
         env_period_ff <= 4'd0;
         length_ff     <= 8'd0;
         restart_ff    <= 1'b0;
         divider_ff    <= 4'd0;
         decay_ff      <= 4'd0;
         enabled_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         lfsr_ff       <= lfsr_in;
         timer_ff      <= timer_in;
         reload_ff     <= reload_in;
         short_ff      <= short_in;
         halt_ff       <= halt_in;
         const_vol_ff  <= const_vol_in;
         env_period_ff <= env_period_in;
         length_ff     <= length_in;
         restart_ff    <= restart_in;
         divider_ff    <= divider_in;
         decay_ff      <= decay_in;
         enabled_ff    <= enabled_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != 15'd0)
      else $error("Noise shift register reached the all-zero lockup state.");

   a_disable_clears_length: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_cmd.op == ncle_pkg::OP_ENABLE && !pop_cmd.data[0])
      |=> (length_ff == 8'd0 && !rsp_data_ff[4]))
      else $error("Disabling the voice did not clear the length counter.");
`endif

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the noise voice core. A directed table covers the
// reset state, the register fields, every request type and the corner cases
// of the length counter and envelope. A weighted random stream follows. Each
// result is checked against a table row or a behavioral model of the voice,
// with random idling on both streams, one long result stall and drain pauses.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TW = ncle_pkg::NCLE_TIMER_WIDTH;
   localparam int RANDOM_BEATS = 675;
   localparam int IDLE_PERCENT = 22;
   localparam int HOLDOFF_CYCLES = 60;
   localparam logic [1:0] REG_SPARE = 2'd1;
   localparam logic [2:0] REQ_RESERVED_MIN = 3'd5;
   localparam logic [2:0] REQ_RESERVED_MAX = 3'd7;

   typedef struct packed {
      logic [3:0] sample;
      logic       active;
   } voice_result_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [1:0] idx;
      logic [7:0] wdata;
      logic       typed;
      logic [3:0] sample;
      logic       active;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = 3'd0;   // [2:0] req_type
   logic [15:0] req_tdata = 16'd0;  // [1:0] reg_offset, [9:2] write_data
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [3:0] sample, [4] length_active

   // Voice model state.
   logic [14:0]   noise_sr = 15'd1;
   logic [TW-1:0] tick_count = '0;
   logic [TW-1:0] tick_reload = TW'(4);
   logic          short_taps = 1'b0;
   logic          halt_flag = 1'b0;
   logic          fixed_volume = 1'b0;
   logic [3:0]    volume_period = 4'd0;
   logic [7:0]    len_count = 8'd0;
   logic          env_restart_pending = 1'b0;
   logic [3:0]    env_div = 4'd0;
   logic [3:0]    env_level = 4'd0;
   logic          voice_on = 1'b0;

   int period_steps [16] = '{4, 8, 16, 32, 64, 96, 128, 160,
                             202, 254, 380, 508, 762, 1016, 2034, 4068};
   int length_steps [32] = '{10, 254, 20, 2, 40, 4, 80, 6, 160, 8, 60, 10, 14, 12, 26, 14,
                             12, 16, 24, 18, 48, 20, 96, 22, 192, 24, 72, 26, 16, 28, 32, 30};

   stim_row_type directed_rows [25] = '{
      '{ncle_pkg::REQ_TIMER,     2'd0,                  8'h00, 1'b1, 4'd0,  1'b0},
      '{REQ_RESERVED_MIN,        2'd3,                  8'hFF, 1'b1, 4'd0,  1'b0},
      '{REQ_RESERVED_MAX,        2'd0,                  8'h00, 1'b1, 4'd0,  1'b0},
      '{ncle_pkg::REQ_LENGTH,    2'd0,                  8'h00, 1'b1, 4'd0,  1'b0},
      '{ncle_pkg::REQ_REG_WRITE, ncle_pkg::REG_LENGTH,  8'hFF, 1'b1, 4'd0,  1'b0},
      '{ncle_pkg::REQ_ENABLE,    2'd0,                  8'hFF, 1'b1, 4'd0,  1'b0},
      '{ncle_pkg::REQ_REG_WRITE, ncle_pkg::REG_CONTROL, 8'h3F, 1'b1, 4'd0,  1'b0},
      '{ncle_pkg::REQ_REG_WRITE, ncle_pkg::REG_LENGTH,  8'hFF, 1'b1, 4'd15, 1'b1},
      '{ncle_pkg::REQ_LENGTH,    2'd0,                  8'h00, 1'b1, 4'd15, 1'b1},
      '{ncle_pkg::REQ_ENVELOPE,  2'd0,                  8'h00, 1'b1, 4'd15, 1'b1},
      '{ncle_pkg::REQ_REG_WRITE, ncle_pkg::REG_CONTROL, 8'hC0, 1'b1, 4'd15, 1'b1},
      '{ncle_pkg::REQ_ENVELOPE,  2'd0,                  8'h00, 1'b0, 4'd0,  1'b0},
      '{ncle_pkg::REQ_REG_WRITE, ncle_pkg::REG_PERIOD,  8'h80, 1'b0, 4'd0,  1'b0},
      '{ncle_pkg::REQ_TIMER,     2'd0,                  8'h00, 1'b0, 4'd0,  1'b0},
      '{ncle_pkg::REQ_REG_WRITE, ncle_pkg::REG_PERIOD,  8'h0F, 1'b0, 4'd0,  1'b0},
      '{ncle_pkg::REQ_REG_WRITE, REG_SPARE,             8'hA5, 1'b0, 4'd0,  1'b0},
      '{ncle_pkg::REQ_LENGTH,    2'd0,                  8'h00, 1'b0, 4'd0,  1'b0},
      '{ncle_pkg::REQ_REG_WRITE, ncle_pkg::REG_LENGTH,  8'h08, 1'b0, 4'd0,  1'b0},
      '{ncle_pkg::REQ_ENABLE,    2'd0,                  8'hFE, 1'b1, 4'd0,  1'b0},
      '{ncle_pkg::REQ_ENABLE,    2'd3,                  8'h01, 1'b1, 4'd0,  1'b0},
      '{ncle_pkg::REQ_REG_WRITE, ncle_pkg::REG_LENGTH,  8'h18, 1'b0, 4'd0,  1'b0},
      '{ncle_pkg::REQ_LENGTH,    2'd0,                  8'h00, 1'b0, 4'd0,  1'b0},
      '{ncle_pkg::REQ_LENGTH,    2'd0,                  8'h00, 1'b1, 4'd0,  1'b0},
      '{ncle_pkg::REQ_REG_WRITE, ncle_pkg::REG_CONTROL, 8'h20, 1'b0, 4'd0,  1'b0},
      '{ncle_pkg::REQ_ENVELOPE,  2'd0,                  8'h00, 1'b0, 4'd0,  1'b0}
   };

   voice_result_type expected_voice [$];
   int  kind_seen [8];
   int  results_checked = 0;
   int  error_count = 0;
   logic calm = 1'b0;
   logic holdoff_req = 1'b0;
   logic holdoff_taken = 1'b0;
   int  holdoff_left = 0;

   noise_channel_lfsr_envelope_core #(
      .TIMER_WIDTH(TW)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic voice_update(input logic [2:0] kind, input logic [1:0] idx,
                               input logic [7:0] wdata, output voice_result_type res);
      logic fb;
      case (kind)
         ncle_pkg::REQ_REG_WRITE: begin
            case (idx)
               ncle_pkg::REG_CONTROL: begin
                  halt_flag = wdata[5];
                  fixed_volume = wdata[4];
                  volume_period = wdata[3:0];
               end
               ncle_pkg::REG_PERIOD: begin
                  short_taps = wdata[7];
                  tick_reload = TW'(period_steps[wdata[3:0]]);
               end
               ncle_pkg::REG_LENGTH: begin
                  if (voice_on) len_count = 8'(length_steps[wdata[7:3]]);
                  env_restart_pending = 1'b1;
               end
               default: ;
            endcase
         end
         ncle_pkg::REQ_TIMER: begin
            if (tick_count == 0) begin
               tick_count = tick_reload;
               fb = noise_sr[0] ^ (short_taps ? noise_sr[6] : noise_sr[1]);
               noise_sr = {fb, noise_sr[14:1]};
            end else begin
               tick_count = tick_count - 1'b1;
            end
         end
         ncle_pkg::REQ_ENVELOPE: begin
            if (env_restart_pending) begin
               env_restart_pending = 1'b0;
               env_level = 4'd15;
               env_div = volume_period;
            end else if (env_div == 4'd0) begin
               env_div = volume_period;
               if (env_level != 4'd0) env_level = env_level - 1'b1;
               else if (halt_flag) env_level = 4'd15;
            end else begin
               env_div = env_div - 1'b1;
            end
         end
         ncle_pkg::REQ_LENGTH: begin
            if (!halt_flag && len_count != 8'd0) len_count = len_count - 1'b1;
         end
         ncle_pkg::REQ_ENABLE: begin
            voice_on = wdata[0];
            if (!voice_on) len_count = 8'd0;
         end
         default: ;
      endcase
      res.active = (len_count != 8'd0);
      if (len_count == 8'd0 || noise_sr[0]) res.sample = 4'd0;
      else res.sample = fixed_volume ? volume_period : env_level;
   endtask

   task automatic send_beat(input logic [2:0] kind, input logic [1:0] idx,
                            input logic [7:0] wdata, input logic typed,
                            input voice_result_type typed_res);
      voice_result_type res;
      if (!calm) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'd0, wdata, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      voice_update(kind, idx, wdata, res);
      expected_voice.push_back(typed ? typed_res : res);
      kind_seen[kind]++;
      @(negedge clock);
   endtask

   task automatic drain_pause();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (expected_voice.size() != 0) @(negedge clock);
   endtask

   task automatic pick_random(output logic [2:0] kind, output logic [1:0] idx,
                              output logic [7:0] wdata);
      int r;
      r = $urandom_range(0, 99);
      wdata = 8'($urandom);
      idx = 2'($urandom);
      if (r < 35) kind = ncle_pkg::REQ_TIMER;
      else if (r < 50) kind = ncle_pkg::REQ_ENVELOPE;
      else if (r < 60) kind = ncle_pkg::REQ_LENGTH;
      else if (r < 88) kind = ncle_pkg::REQ_REG_WRITE;
      else if (r < 94) kind = ncle_pkg::REQ_ENABLE;
      else kind = 3'($urandom_range(REQ_RESERVED_MIN, REQ_RESERVED_MAX));
      if (kind == ncle_pkg::REQ_REG_WRITE) begin
         r = $urandom_range(0, 9);
         idx = (r < 3) ? ncle_pkg::REG_CONTROL :
               (r < 6) ? ncle_pkg::REG_PERIOD :
               (r < 9) ? ncle_pkg::REG_LENGTH : REG_SPARE;
         if (idx == ncle_pkg::REG_CONTROL && $urandom_range(0, 3) != 0)
            wdata[3:0] = 4'($urandom_range(0, 2));
         if (idx == ncle_pkg::REG_PERIOD && $urandom_range(0, 3) != 0)
            wdata[3:0] = 4'($urandom_range(0, 3));
      end
      if (kind == ncle_pkg::REQ_ENABLE && $urandom_range(0, 3) != 0) wdata[0] = 1'b1;
   endtask

   always @(negedge clock) begin
      if (holdoff_req && !holdoff_taken) begin
         holdoff_taken = 1'b1;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
         holdoff_left = holdoff_left - 1;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      voice_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_voice.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual sample %0d active %0d",
                     $time, rsp_tdata[3:0], rsp_tdata[4]);
            error_count++;
         end else begin
            want = expected_voice.pop_front();
            results_checked++;
            if (rsp_tdata[3:0] !== want.sample) begin
               $display("%0t: sample mismatch, expected %0d, actual %0d",
                        $time, want.sample, rsp_tdata[3:0]);
               error_count++;
            end
            if (rsp_tdata[4] !== want.active) begin
               $display("%0t: length_active mismatch, expected %0d, actual %0d",
                        $time, want.active, rsp_tdata[4]);
               error_count++;
            end
         end
      end
   end

   initial begin
      #1_000_000;
      $display("%0t: timeout with %0d results outstanding", $time, expected_voice.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [2:0] kind;
      logic [1:0] idx;
      logic [7:0] wdata;
      int reserved_total;
      foreach (kind_seen[k]) kind_seen[k] = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].kind, directed_rows[i].idx, directed_rows[i].wdata,
                   directed_rows[i].typed, {directed_rows[i].sample, directed_rows[i].active});
      end
      drain_pause();

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == 200) holdoff_req = 1'b1;
         calm = (n >= 200 && n < 240) || (n >= 400 && n < 520);
         if (n == 600) drain_pause();
         pick_random(kind, idx, wdata);
         send_beat(kind, idx, wdata, 1'b0, '0);
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (expected_voice.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      reserved_total = 0;
      for (int k = int'(REQ_RESERVED_MIN); k <= int'(REQ_RESERVED_MAX); k++) begin
         reserved_total += kind_seen[k];
      end
      $display("Sent %0d timer ticks, %0d envelope clocks, %0d length clocks, %0d register writes,",
               kind_seen[ncle_pkg::REQ_TIMER], kind_seen[ncle_pkg::REQ_ENVELOPE],
               kind_seen[ncle_pkg::REQ_LENGTH], kind_seen[ncle_pkg::REQ_REG_WRITE]);
      $display("%0d enable writes and %0d reserved requests; %0d result beats compared.",
               kind_seen[ncle_pkg::REQ_ENABLE], reserved_total, results_checked);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/ncle_pkg.sv
sv/ncle_front.sv
sv/ncle_queue.sv
sv/ncle_back.sv
sv/noise_channel_lfsr_envelope_core.sv
tb/tb_top.sv
